@@ src/rpd_pkg.sv @@
package rpd_pkg;

   typedef enum logic {
      KIND_DATA = 1'b0,
      KIND_END  = 1'b1
   } kind_type;

   typedef enum logic {
      CAUSE_TERMINATOR   = 1'b0,
      CAUSE_SYMBOL_ERROR = 1'b1
   } cause_type;

   typedef enum logic [0:0] {
      CSR_MAX_PACKET_LEN = 1'b0,
      CSR_CRC_POLY       = 1'b1
   } csr_index_type;

   localparam logic [7:0] MAX_PACKET_LEN_RESET = 8'd250;
   localparam logic [7:0] CRC_POLY_RESET       = 8'h9b;
   localparam logic [4:0] SYM_INVALID          = 5'd16;
   localparam logic [7:0] COUNT_MAX            = 8'hff;

   // result queue
   localparam int unsigned FIFO_DEPTH        = 4;
   localparam int unsigned FIFO_PTR_W        = $clog2(FIFO_DEPTH);
   localparam int unsigned FIFO_CNT_W        = $clog2(FIFO_DEPTH + 1);
   localparam logic [FIFO_CNT_W-1:0] FIFO_ACCEPT_LIMIT = FIFO_CNT_W'(FIFO_DEPTH - 2);

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data_byte;
      logic       last;
      logic [7:0] seq_number;
      logic [7:0] packet_len;
      logic [7:0] crc_calc;
      logic [7:0] crc_rx;
      logic       crc_ok;
      cause_type  end_cause;
      logic       overlong;
      logic [7:0] rssi_out;
      logic [7:0] error_total;
   } result_type;

   // 4b6b symbol to nibble, SYM_INVALID for codes with no nibble
   function automatic logic [4:0] sym_decode(input logic [5:0] sym);
      logic [4:0] nib;
      case (sym)
         6'd11: nib = 5'd11;
         6'd13: nib = 5'd13;
         6'd14: nib = 5'd14;
         6'd21: nib = 5'd0;
         6'd22: nib = 5'd7;
         6'd25: nib = 5'd9;
         6'd26: nib = 5'd8;
         6'd28: nib = 5'd15;
         6'd35: nib = 5'd3;
         6'd37: nib = 5'd5;
         6'd38: nib = 5'd6;
         6'd42: nib = 5'd10;
         6'd44: nib = 5'd12;
         6'd49: nib = 5'd1;
         6'd50: nib = 5'd2;
         6'd52: nib = 5'd4;
         default: nib = SYM_INVALID;
      endcase
      return nib;
   endfunction

   // crc-8, msb first, one byte
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data,
                                            input logic [7:0] poly);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ poly;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

@@ src/rpd_req_if.sv @@
interface rpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] raw_byte;
   logic [7:0] rssi;

   modport source (output valid, output raw_byte, output rssi, input ready);
   modport sink (input valid, input raw_byte, input rssi, output ready);
endinterface

@@ src/rpd_rsp_if.sv @@
interface rpd_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] data_byte;
   logic       last;
   logic [7:0] seq_number;
   logic [7:0] packet_len;
   logic [7:0] crc_calc;
   logic [7:0] crc_rx;
   logic       crc_ok;
   logic       end_cause;
   logic       overlong;
   logic [7:0] rssi_out;
   logic [7:0] error_total;

   modport source (output valid, output kind, output data_byte, output last,
                   output seq_number, output packet_len, output crc_calc, output crc_rx,
                   output crc_ok, output end_cause, output overlong, output rssi_out,
                   output error_total, input ready);
   modport sink (input valid, input kind, input data_byte, input last,
                 input seq_number, input packet_len, input crc_calc, input crc_rx,
                 input crc_ok, input end_cause, input overlong, input rssi_out,
                 input error_total, output ready);
endinterface

@@ src/radio_4b6b_packet_decoder.sv @@
// 4b6b radio packet decoder with crc-8 check.
// req_chan carries raw received bytes with the current rssi; a zero byte ends
// a packet. rsp_chan carries decoded data bytes (kind 0) and packet end records
// (kind 1); last marks the final result caused by one input byte.
// csr_we/csr_index/csr_wdata write max_packet_len (index 0) and crc_poly
// (index 1); write only while the block is idle.
// Each input byte is decoded in the cycle it transfers: up to two 6-bit symbol
// lookups and one crc byte step sit between the state registers and a
// four-entry result queue. A byte causes zero, one or two results; they are
// written into the registered queue and reach rsp_chan from its head.
// One byte is accepted per cycle as long as the queue holds two results or
// fewer, so throughput is one byte per cycle while each byte yields at most
// one result, and is set by the single-entry-per-cycle queue read otherwise.
// When the receiver stalls the queue fills and req_chan.ready drops once three
// results are waiting; nothing is lost.
// Reset (synchronous, active high) empties the queue, clears symbol and packet
// state, zeroes the packet sequence number and sets max_packet_len to 250 and
// crc_poly to 0x9b.
module radio_4b6b_packet_decoder (
   input  logic             clock,
   input  logic             reset,
   rpd_req_if.sink          req_chan,
   rpd_rsp_if.source        rsp_chan,
   input  logic             csr_we,
   input  logic [0:0]       csr_index,
   input  logic [7:0]       csr_wdata
);
   import rpd_pkg::*;

   // configuration
   logic [7:0] max_len_ff;
   logic [7:0] poly_ff;

   // decoder state
   logic [15:0] shift_ff, shift_in;
   logic [3:0]  bit_count_ff, bit_count_in;
   logic [3:0]  nib_hold_ff, nib_hold_in;
   logic        nib_valid_ff, nib_valid_in;
   logic [7:0]  pkt_len_ff, pkt_len_in;
   logic [7:0]  crc_run_ff, crc_run_in;
   logic [7:0]  crc_prev_ff, crc_prev_in;
   logic [7:0]  last_data_ff, last_data_in;
   logic [7:0]  seq_ff, seq_in;
   logic [7:0]  err_cnt_ff, err_cnt_in;

   // result queue
   result_type                fifo_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]     count_ff, count_in;

   result_type  res0, res1;
   logic [1:0]  n_res;
   logic        take;
   logic        pop;
   result_type  head;

   function automatic result_type end_record(
      input logic [7:0] seq, input logic [7:0] len, input logic [7:0] crc_prev,
      input logic [7:0] last_data, input cause_type cause, input logic [7:0] max_len,
      input logic [7:0] rssi, input logic [7:0] err_cnt);
      result_type r;
      r             = '0;
      r.kind        = KIND_END;
      r.last        = 1'b1;
      r.seq_number  = seq;
      r.packet_len  = len;
      r.crc_calc    = (len != 8'd0) ? crc_prev : 8'd0;
      r.crc_rx      = (len != 8'd0) ? last_data : 8'd0;
      r.crc_ok      = (len != 8'd0) && (crc_prev == last_data);
      r.end_cause   = cause;
      r.overlong    = (len >= max_len);
      r.rssi_out    = rssi;
      r.error_total = err_cnt;
      return r;
   endfunction

   assign take = req_chan.valid && req_chan.ready;
   assign pop  = rsp_chan.valid && rsp_chan.ready;
   assign req_chan.ready = (count_ff <= FIFO_ACCEPT_LIMIT);

   always_comb begin
      logic [4:0] cnt_wide;
      logic [3:0] cnt;
      logic       done;
      logic [5:0] sym;
      logic [4:0] nib;
      logic [7:0] dec_byte;
      logic [15:0] shifted;

      shift_in     = shift_ff;
      bit_count_in = bit_count_ff;
      nib_hold_in  = nib_hold_ff;
      nib_valid_in = nib_valid_ff;
      pkt_len_in   = pkt_len_ff;
      crc_run_in   = crc_run_ff;
      crc_prev_in  = crc_prev_ff;
      last_data_in = last_data_ff;
      seq_in       = seq_ff;
      err_cnt_in   = err_cnt_ff;
      res0         = '0;
      res1         = '0;
      n_res        = 2'd0;
      cnt_wide     = '0;
      cnt          = '0;
      done         = 1'b0;
      sym          = '0;
      nib          = '0;
      dec_byte     = '0;
      shifted      = '0;

      if (take) begin
         if (req_chan.raw_byte == 8'd0) begin
            res0  = end_record(seq_ff, pkt_len_ff, crc_prev_ff, last_data_ff,
                               CAUSE_TERMINATOR, max_len_ff, req_chan.rssi, err_cnt_ff);
            n_res = 2'd1;
            seq_in       = seq_ff + 8'd1;
            shift_in     = '0;
            bit_count_in = '0;
            nib_hold_in  = '0;
            nib_valid_in = 1'b0;
            err_cnt_in   = '0;
            pkt_len_in   = '0;
            crc_run_in   = '0;
            crc_prev_in  = '0;
            last_data_in = '0;
         end else begin
            shift_in = {shift_ff[7:0], req_chan.raw_byte};
            cnt_wide = {1'b0, bit_count_ff} + 5'd8;
            cnt      = (cnt_wide > 5'd15) ? 4'd15 : cnt_wide[3:0];
            // at most two symbols fit in the queued bits
            for (int i = 0; i < 2; i++) begin
               if (!done && cnt >= 4'd6) begin
                  cnt     = cnt - 4'd6;
                  shifted = shift_in >> cnt;
                  sym     = shifted[5:0];
                  if (sym != 6'd0) begin
                     nib = sym_decode(sym);
                     if (nib == SYM_INVALID) begin
                        if (err_cnt_in != COUNT_MAX) begin
                           err_cnt_in = err_cnt_in + 8'd1;
                        end
                        done = 1'b1;
                     end else if (nib_valid_in) begin
                        dec_byte       = {nib_hold_in, nib[3:0]};
                        res0           = '0;
                        res0.kind      = KIND_DATA;
                        res0.data_byte = dec_byte;
                        res0.last      = 1'b1;
                        n_res          = 2'd1;
                        crc_prev_in    = crc_run_in;
                        crc_run_in     = crc8_byte(crc_run_in, dec_byte, poly_ff);
                        last_data_in   = dec_byte;
                        if (pkt_len_in != COUNT_MAX) begin
                           pkt_len_in = pkt_len_in + 8'd1;
                        end
                        nib_valid_in = 1'b0;
                        nib_hold_in  = '0;
                     end else begin
                        nib_hold_in  = nib[3:0];
                        nib_valid_in = 1'b1;
                     end
                  end
               end
            end
            bit_count_in = cnt;

            // an error ends a non-empty packet, also one counted while it was empty
            if (err_cnt_in != 8'd0 && pkt_len_in != 8'd0) begin
               if (n_res == 2'd1) begin
                  res0.last = 1'b0;
                  res1  = end_record(seq_in, pkt_len_in, crc_prev_in, last_data_in,
                                     CAUSE_SYMBOL_ERROR, max_len_ff, req_chan.rssi,
                                     err_cnt_in);
                  n_res = 2'd2;
               end else begin
                  res0  = end_record(seq_in, pkt_len_in, crc_prev_in, last_data_in,
                                     CAUSE_SYMBOL_ERROR, max_len_ff, req_chan.rssi,
                                     err_cnt_in);
                  n_res = 2'd1;
               end
               seq_in       = seq_ff + 8'd1;
               shift_in     = '0;
               bit_count_in = '0;
               nib_hold_in  = '0;
               nib_valid_in = 1'b0;
               err_cnt_in   = '0;
               pkt_len_in   = '0;
               crc_run_in   = '0;
               crc_prev_in  = '0;
               last_data_in = '0;
            end
         end
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(n_res);
      rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(pop);
      count_in  = count_ff + FIFO_CNT_W'(n_res) - FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff   <= MAX_PACKET_LEN_RESET;
         poly_ff      <= CRC_POLY_RESET;
         shift_ff     <= '0;
         bit_count_ff <= '0;
         nib_hold_ff  <= '0;
         nib_valid_ff <= 1'b0;
         pkt_len_ff   <= '0;
         crc_run_ff   <= '0;
         crc_prev_ff  <= '0;
         last_data_ff <= '0;
         seq_ff       <= '0;
         err_cnt_ff   <= '0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_MAX_PACKET_LEN: max_len_ff <= csr_wdata;
               CSR_CRC_POLY:       poly_ff    <= csr_wdata;
               default: ;
            endcase
         end
         shift_ff     <= shift_in;
         bit_count_ff <= bit_count_in;
         nib_hold_ff  <= nib_hold_in;
         nib_valid_ff <= nib_valid_in;
         pkt_len_ff   <= pkt_len_in;
         crc_run_ff   <= crc_run_in;
         crc_prev_ff  <= crc_prev_in;
         last_data_ff <= last_data_in;
         seq_ff       <= seq_in;
         err_cnt_ff   <= err_cnt_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
      end
   end

   // queue storage, up to two entries written per transfer
   always_ff @(posedge clock) begin
      if (n_res != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= res0;
      end
      if (n_res == 2'd2) begin
         fifo_ff[wr_ptr_ff + FIFO_PTR_W'(1)] <= res1;
      end
   end

   assign head = fifo_ff[rd_ptr_ff];

   assign rsp_chan.valid       = (count_ff != '0);
   assign rsp_chan.kind        = head.kind;
   assign rsp_chan.data_byte   = head.data_byte;
   assign rsp_chan.last        = head.last;
   assign rsp_chan.seq_number  = head.seq_number;
   assign rsp_chan.packet_len  = head.packet_len;
   assign rsp_chan.crc_calc    = head.crc_calc;
   assign rsp_chan.crc_rx      = head.crc_rx;
   assign rsp_chan.crc_ok      = head.crc_ok;
   assign rsp_chan.end_cause   = head.end_cause;
   assign rsp_chan.overlong    = head.overlong;
   assign rsp_chan.rssi_out    = head.rssi_out;
   assign rsp_chan.error_total = head.error_total;

endmodule

@@ src/rpd_checker.sv @@
module rpd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_kind,
   input logic [7:0] rsp_data_byte,
   input logic       rsp_last,
   input logic [7:0] rsp_packet_len,
   input logic [7:0] rsp_crc_calc,
   input logic [7:0] rsp_crc_rx,
   input logic       rsp_crc_ok
);
   import rpd_pkg::*;

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid
         && $stable({rsp_kind, rsp_data_byte, rsp_last, rsp_packet_len}))
      else $error("stalled result changed");

   // an end record is always the final result of its input byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_END |-> rsp_last)
      else $error("end record without last");

   // a data byte not marked last is followed at once by its end record
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_kind == KIND_DATA && !rsp_last
         |=> rsp_valid && rsp_kind == KIND_END)
      else $error("missing end record after data byte");

   // crc match needs a non-empty packet and equal values
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_END && rsp_crc_ok
         |-> rsp_packet_len != 8'd0 && rsp_crc_calc == rsp_crc_rx)
      else $error("inconsistent crc_ok");

endmodule

bind radio_4b6b_packet_decoder rpd_checker u_rpd_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_kind       (rsp_chan.kind),
   .rsp_data_byte  (rsp_chan.data_byte),
   .rsp_last       (rsp_chan.last),
   .rsp_packet_len (rsp_chan.packet_len),
   .rsp_crc_calc   (rsp_chan.crc_calc),
   .rsp_crc_rx     (rsp_chan.crc_rx),
   .rsp_crc_ok     (rsp_chan.crc_ok)
);
